>>> src/lstc_pkg.sv
// shared types, widths and constants of the laser scan to cartesian core
package lstc_pkg;

	// field widths
	localparam int BEAM_W    = 12;
	localparam int ANGLE_W   = 16;
	localparam int RANGE_W   = 16;
	localparam int OFFSET_W  = 24;
	localparam int LASER_W   = 17;
	localparam int MAP_W     = 25;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	// fixed point widths of the sine series
	localparam int U_W   = 15;
	localparam int X_W   = 31;
	localparam int X2_W  = 32;
	localparam int PQ_W  = 31;
	localparam int MAG_W = 17;

	localparam logic [X_W-1:0]     PI_HALF_Q30 = 31'd1686629713;
	localparam logic [PQ_W-1:0]    ONE_Q30     = 31'd1073741824;
	localparam logic [U_W-1:0]     QUARTER     = 15'd16384;
	localparam logic [ANGLE_W-1:0] QUARTER_ANG = 16'd16384;
	localparam logic [MAG_W-1:0]   SINE_ONE    = 17'd65536;

	// four trig lanes: cos and sin of beam angle, cos and sin of map angle
	localparam int LANES      = 4;
	localparam int LANE_COS_A = 0;
	localparam int LANE_SIN_A = 1;
	localparam int LANE_COS_M = 2;
	localparam int LANE_SIN_M = 3;

	// pipeline layout
	localparam int CELLS         = 4;
	localparam int FRONT_STAGES  = 3;
	localparam int CELL_STAGES   = 3;
	localparam int BACK_STAGES   = 4;
	localparam int PIPE_STAGES   = FRONT_STAGES + CELLS * CELL_STAGES + BACK_STAGES;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_ANGLE = 3'd0,
		REG_ANGLE_STEP  = 3'd1,
		REG_MIN_RANGE   = 3'd2,
		REG_MAX_RANGE   = 3'd3,
		REG_OFFSET_X    = 3'd4,
		REG_OFFSET_Y    = 3'd5,
		REG_HEADING     = 3'd6,
		REG_MAP_ENABLE  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]  start_angle;
		logic [ANGLE_W-1:0]  angle_step;
		logic [RANGE_W-1:0]  min_range;
		logic [RANGE_W-1:0]  max_range;
		logic [OFFSET_W-1:0] offset_x;
		logic [OFFSET_W-1:0] offset_y;
		logic [ANGLE_W-1:0]  heading;
		logic                map_enable;
	} cfg_t;

	// per beat sideband
	typedef struct packed {
		logic [BEAM_W-1:0]  beam;
		logic [RANGE_W-1:0] range;
		logic               last;
	} side_t;

	// per lane series operands
	typedef struct packed {
		logic            neg;
		logic [X_W-1:0]  x;
		logic [X2_W-1:0] x2;
	} lane_t;

	// divisor of each series cell, from the innermost term out
	function automatic int unsigned series_divisor(input int unsigned idx);
		int unsigned d;
		case (idx)
			0: d = 72;
			1: d = 42;
			2: d = 20;
			3: d = 6;
			default: d = 6;
		endcase
		return d;
	endfunction

endpackage

>>> src/lstc_front.sv
// beam angle and counter state, range filter and series operand stages
module lstc_front import lstc_pkg::*; #(
	parameter int MAX_BEAMS  = 4096,
	parameter int ANGLE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [RANGE_W-1:0]       range_mm,
	input  logic                     range_finite,
	input  logic                     scan_end,
	input  cfg_t                     cfg,
	input  logic                     start_load,
	input  logic [ANGLE_W-1:0]       start_value,
	input  logic [FRONT_STAGES-1:0]  en,
	output logic                     kept,
	output side_t                    side_o,
	output lane_t [LANES-1:0]        lane_o,
	output logic [LANES-1:0][PQ_W-1:0] p_o
);

	localparam int CW  = $clog2(MAX_BEAMS);
	localparam int QSH = (ANGLE_BITS < ANGLE_W) ? ANGLE_W - ANGLE_BITS : 0;
	localparam logic [ANGLE_W-1:0] QMASK = ANGLE_W'({ANGLE_W{1'b1}} << QSH);

	logic [ANGLE_W-1:0] beam_angle_q;
	logic [CW-1:0]      beam_cnt_q;

	logic [ANGLE_W-1:0]       ang_a, ang_m;
	logic [ANGLE_W-1:0]       ang [LANES];
	logic [CW+BEAM_W-1:0]     cnt_wide;
	side_t                    side_c;
	logic [U_W-1:0]           u_c [LANES];
	logic [X_W-1:0]           x_c [LANES];
	logic [X2_W-1:0]          x2_c [LANES];
	logic [U_W+X_W-1:0]       ux_prod [LANES];
	logic [2*X_W-1:0]         xx_prod [LANES];

	side_t                    side_s1, side_s2, side_s3;
	logic [U_W-1:0]           u_s1 [LANES];
	logic                     neg_s1 [LANES];
	logic                     neg_s2 [LANES];
	logic                     neg_s3 [LANES];
	logic [X_W-1:0]           x_s2 [LANES];
	logic [X_W-1:0]           x_s3 [LANES];
	logic [X2_W-1:0]          x2_s3 [LANES];

	// range window filter
	assign kept = range_finite && (range_mm >= cfg.min_range) && (range_mm <= cfg.max_range);

	// running beam angle and beam counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q <= '0;
			beam_cnt_q   <= '0;
		end else if (start_load && (beam_cnt_q == '0)) begin
			beam_angle_q <= start_value;
		end else if (accept) begin
			if (scan_end) begin
				beam_angle_q <= cfg.start_angle;
				beam_cnt_q   <= '0;
			end else begin
				beam_angle_q <= beam_angle_q + cfg.angle_step;
				beam_cnt_q   <= (beam_cnt_q == CW'(MAX_BEAMS - 1)) ? '0 : beam_cnt_q + CW'(1);
			end
		end
	end

	// lane angles folded into a quarter wave
	always_comb begin
		ang_a = beam_angle_q & QMASK;
		ang_m = (beam_angle_q + cfg.heading) & QMASK;
		ang[LANE_COS_A] = ang_a + QUARTER_ANG;
		ang[LANE_SIN_A] = ang_a;
		ang[LANE_COS_M] = ang_m + QUARTER_ANG;
		ang[LANE_SIN_M] = ang_m;
		for (int i = 0; i < LANES; i++) begin
			u_c[i] = ang[i][14] ? QUARTER - U_W'(ang[i][13:0]) : U_W'(ang[i][13:0]);
		end
		cnt_wide     = {{BEAM_W{1'b0}}, beam_cnt_q};
		side_c.beam  = cnt_wide[BEAM_W-1:0];
		side_c.range = range_mm;
		side_c.last  = scan_end;
	end

	// stage 1: quarter wave index
	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1 <= side_c;
			for (int i = 0; i < LANES; i++) begin
				u_s1[i]   <= u_c[i];
				neg_s1[i] <= ang[i][15];
			end
		end
	end

	// radians in q30 and its square
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ux_prod[i] = (U_W+X_W)'(u_s1[i]) * (U_W+X_W)'(PI_HALF_Q30);
			x_c[i]     = ux_prod[i][14 +: X_W];
			xx_prod[i] = (2*X_W)'(x_s2[i]) * (2*X_W)'(x_s2[i]);
			x2_c[i]    = xx_prod[i][30 +: X2_W];
		end
	end

	// stage 2: x
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= side_s1;
			for (int i = 0; i < LANES; i++) begin
				x_s2[i]   <= x_c[i];
				neg_s2[i] <= neg_s1[i];
			end
		end
	end

	// stage 3: x squared
	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s3 <= side_s2;
			for (int i = 0; i < LANES; i++) begin
				x_s3[i]   <= x_s2[i];
				x2_s3[i]  <= x2_c[i];
				neg_s3[i] <= neg_s2[i];
			end
		end
	end

	// series starts from one
	always_comb begin
		side_o = side_s3;
		for (int i = 0; i < LANES; i++) begin
			lane_o[i].neg = neg_s3[i];
			lane_o[i].x   = x_s3[i];
			lane_o[i].x2  = x2_s3[i];
			p_o[i]        = ONE_Q30;
		end
	end

endmodule

>>> src/lstc_series_cell.sv
// one horner step of the sine series: p = 1 - ((x2 * p) >> 30) / divisor
module lstc_series_cell import lstc_pkg::*; #(
	parameter int unsigned DIVISOR = 6
) (
	input  logic                       clk,
	input  logic [CELL_STAGES-1:0]     en,
	input  side_t                      side_i,
	input  lane_t [LANES-1:0]          lane_i,
	input  logic [LANES-1:0][PQ_W-1:0] p_i,
	output side_t                      side_o,
	output lane_t [LANES-1:0]          lane_o,
	output logic [LANES-1:0][PQ_W-1:0] p_o
);

	// reciprocal below 2^32, quotient off by at most one
	localparam int unsigned SHIFT = 32 + $clog2(DIVISOR + 1) - 1;
	localparam logic [X2_W-1:0] RECIP = X2_W'((64'd1 << SHIFT) / DIVISOR);

	side_t             side_s1, side_s2, side_s3;
	lane_t [LANES-1:0] lane_s1, lane_s2, lane_s3;
	logic [X2_W-1:0]   t_s1 [LANES];
	logic [X2_W-1:0]   t_s2 [LANES];
	logic [X2_W-1:0]   q_s2 [LANES];
	logic [PQ_W-1:0]   p_s3 [LANES];

	logic [63:0]       xp_prod [LANES];
	logic [63:0]       rq_prod [LANES];
	logic [39:0]       qd [LANES];
	logic [39:0]       rem [LANES];
	logic [X2_W-1:0]   t_c [LANES];
	logic [X2_W-1:0]   q_c [LANES];
	logic [X2_W-1:0]   qfix [LANES];
	logic [PQ_W-1:0]   p_c [LANES];

	// product, reciprocal multiply and quotient correction
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			xp_prod[i] = 64'(lane_i[i].x2) * 64'(p_i[i]);
			t_c[i]     = xp_prod[i][30 +: X2_W];
			rq_prod[i] = 64'(t_s1[i]) * 64'(RECIP);
			q_c[i]     = X2_W'(rq_prod[i] >> SHIFT);
			qd[i]      = 40'(q_s2[i]) * 40'(DIVISOR);
			rem[i]     = 40'(t_s2[i]) - qd[i];
			qfix[i]    = q_s2[i] + X2_W'(rem[i] >= 40'(DIVISOR));
			p_c[i]     = ONE_Q30 - PQ_W'(qfix[i]);
		end
	end

	// stage 1: scaled product
	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1 <= side_i;
			lane_s1 <= lane_i;
			for (int i = 0; i < LANES; i++) t_s1[i] <= t_c[i];
		end
	end

	// stage 2: estimated quotient
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= side_s1;
			lane_s2 <= lane_s1;
			for (int i = 0; i < LANES; i++) begin
				t_s2[i] <= t_s1[i];
				q_s2[i] <= q_c[i];
			end
		end
	end

	// stage 3: next series term
	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s3 <= side_s2;
			lane_s3 <= lane_s2;
			for (int i = 0; i < LANES; i++) p_s3[i] <= p_c[i];
		end
	end

	always_comb begin
		side_o = side_s3;
		lane_o = lane_s3;
		for (int i = 0; i < LANES; i++) p_o[i] = p_s3[i];
	end

endmodule

>>> src/lstc_back.sv
// sine finish, range scaling, map offset and output registers
module lstc_back import lstc_pkg::*; (
	input  logic                       clk,
	input  logic [BACK_STAGES-1:0]     en,
	input  side_t                      side_i,
	input  lane_t [LANES-1:0]          lane_i,
	input  logic [LANES-1:0][PQ_W-1:0] p_i,
	input  cfg_t                       cfg,
	output logic [BEAM_W-1:0]          beam_number,
	output logic signed [LASER_W-1:0]  laser_x,
	output logic signed [LASER_W-1:0]  laser_y,
	output logic signed [MAP_W-1:0]    map_x,
	output logic signed [MAP_W-1:0]    map_y,
	output logic                       map_valid,
	output logic                       end_of_scan
);

	side_t              side_s1, side_s2, side_s3;
	logic               neg_s1 [LANES];
	logic               neg_s2 [LANES];
	logic               neg_s3 [LANES];
	logic [X2_W-1:0]    v_s1 [LANES];
	logic [MAG_W-1:0]   mag_s2 [LANES];
	logic [32:0]        sp_s3 [LANES];

	logic [2*X_W-1:0]   xp_prod [LANES];
	logic [X2_W-1:0]    v_c [LANES];
	logic [X2_W:0]      v_rnd [LANES];
	logic [MAG_W-1:0]   mag_c [LANES];
	logic [32:0]        sp_c [LANES];
	logic [33:0]        sp_rnd [LANES];
	logic [LASER_W-1:0] rm [LANES];
	logic [LASER_W-1:0] res [LANES];
	logic [MAP_W-1:0]   mx_c, my_c;

	// sine value, rounding and range product
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			xp_prod[i] = (2*X_W)'(lane_i[i].x) * (2*X_W)'(p_i[i]);
			v_c[i]     = xp_prod[i][30 +: X2_W];
			v_rnd[i]   = ((X2_W+1)'(v_s1[i]) + (X2_W+1)'(8192)) >> 14;
			mag_c[i]   = (v_rnd[i] > (X2_W+1)'(SINE_ONE)) ? SINE_ONE : MAG_W'(v_rnd[i]);
			sp_c[i]    = 33'(side_s2.range) * 33'(mag_s2[i]);
			sp_rnd[i]  = (34'(sp_s3[i]) + 34'd32768) >> 16;
			rm[i]      = LASER_W'(sp_rnd[i]);
			res[i]     = neg_s3[i] ? LASER_W'(-rm[i]) : rm[i];
		end
		mx_c = {{(MAP_W-LASER_W){res[LANE_COS_M][LASER_W-1]}}, res[LANE_COS_M]}
			+ {cfg.offset_x[OFFSET_W-1], cfg.offset_x};
		my_c = {{(MAP_W-LASER_W){res[LANE_SIN_M][LASER_W-1]}}, res[LANE_SIN_M]}
			+ {cfg.offset_y[OFFSET_W-1], cfg.offset_y};
	end

	// stage 1: x times series
	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1 <= side_i;
			for (int i = 0; i < LANES; i++) begin
				v_s1[i]   <= v_c[i];
				neg_s1[i] <= lane_i[i].neg;
			end
		end
	end

	// stage 2: q16 sine magnitude
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= side_s1;
			for (int i = 0; i < LANES; i++) begin
				mag_s2[i] <= mag_c[i];
				neg_s2[i] <= neg_s1[i];
			end
		end
	end

	// stage 3: range times sine
	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s3 <= side_s2;
			for (int i = 0; i < LANES; i++) begin
				sp_s3[i]  <= sp_c[i];
				neg_s3[i] <= neg_s2[i];
			end
		end
	end

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (en[3]) begin
			beam_number <= side_s3.beam;
			end_of_scan <= side_s3.last;
			laser_x     <= res[LANE_COS_A];
			laser_y     <= res[LANE_SIN_A];
			map_valid   <= cfg.map_enable;
			map_x       <= cfg.map_enable ? mx_c : '0;
			map_y       <= cfg.map_enable ? my_c : '0;
		end
	end

endmodule

>>> src/laser_scan_to_cartesian_core.sv
// top level of the laser scan to cartesian core
//
// Takes one lidar range sample per input beat (range_mm, range_finite,
// scan_end) and returns one point beat per kept sample: beam number,
// sensor-frame x/y and, when map_enable is set, map-frame x/y.
// Samples that are not finite or lie outside the range window give no
// output beat; beam angle and beam counter still advance, and both
// restart after a beat with scan_end set.
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low. Configuration is a write port (cfg_write, cfg_index,
// cfg_data), to be used only while the core is idle; it is not enforced.
// The pipe has 3 operand stages, a row of 4 three-stage series cells
// and 4 finishing stages. One beat per cycle is sustained while the
// output is not stalled; the four sine/cosine lanes run side by side.
// Stages with no valid beat fill up while the output is stalled, so the
// input keeps taking beats until every stage holds one.
// Reset clears all valid bits, the beam angle and counter and loads the
// register defaults (max_range all ones, everything else zero).
module laser_scan_to_cartesian_core import lstc_pkg::*; #(
	parameter int MAX_BEAMS  = 4096,
	parameter int ANGLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [RANGE_W-1:0]        range_mm,
	input  logic                      range_finite,
	input  logic                      scan_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [BEAM_W-1:0]         beam_number,
	output logic signed [LASER_W-1:0] laser_x,
	output logic signed [LASER_W-1:0] laser_y,
	output logic signed [MAP_W-1:0]   map_x,
	output logic signed [MAP_W-1:0]   map_y,
	output logic                      map_valid,
	output logic                      end_of_scan
);

	cfg_t                       cfg_q;
	logic [PIPE_STAGES-1:0]     vld_q;
	logic [PIPE_STAGES-1:0]     free;
	logic [PIPE_STAGES-1:0]     vld_d;
	logic                       accept;
	logic                       kept;
	logic                       start_load;

	side_t                      side_c [CELLS+1];
	lane_t [LANES-1:0]          lane_c [CELLS+1];
	logic [LANES-1:0][PQ_W-1:0] p_c [CELLS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{start_angle: '0, angle_step: '0, min_range: '0, max_range: '1,
				offset_x: '0, offset_y: '0, heading: '0, map_enable: 1'b0};
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_START_ANGLE: cfg_q.start_angle <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data[ANGLE_W-1:0];
				REG_MIN_RANGE:   cfg_q.min_range   <= cfg_data[RANGE_W-1:0];
				REG_MAX_RANGE:   cfg_q.max_range   <= cfg_data[RANGE_W-1:0];
				REG_OFFSET_X:    cfg_q.offset_x    <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_Y:    cfg_q.offset_y    <= cfg_data[OFFSET_W-1:0];
				REG_HEADING:     cfg_q.heading     <= cfg_data[ANGLE_W-1:0];
				REG_MAP_ENABLE:  cfg_q.map_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign start_load = cfg_write && (reg_idx_t'(cfg_index) == REG_START_ANGLE);

	// a stage can load when empty or when its beat moves on
	assign free[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !out_stall;
	for (genvar k = 0; k < PIPE_STAGES - 1; k++) begin : g_free
		assign free[k] = !vld_q[k] || free[k+1];
	end

	assign in_stall  = !free[0];
	assign accept    = in_valid && free[0];
	assign out_valid = vld_q[PIPE_STAGES-1];
	assign vld_d     = {vld_q[PIPE_STAGES-2:0], accept && kept};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (free & vld_d) | (~free & vld_q);
		end
	end

	lstc_front #(
		.MAX_BEAMS  (MAX_BEAMS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.range_mm     (range_mm),
		.range_finite (range_finite),
		.scan_end     (scan_end),
		.cfg          (cfg_q),
		.start_load   (start_load),
		.start_value  (cfg_data[ANGLE_W-1:0]),
		.en           (free[FRONT_STAGES-1:0]),
		.kept         (kept),
		.side_o       (side_c[0]),
		.lane_o       (lane_c[0]),
		.p_o          (p_c[0])
	);

	// row of series cells
	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		lstc_series_cell #(
			.DIVISOR (series_divisor(g))
		) u_cell (
			.clk    (clk),
			.en     (free[FRONT_STAGES + g*CELL_STAGES +: CELL_STAGES]),
			.side_i (side_c[g]),
			.lane_i (lane_c[g]),
			.p_i    (p_c[g]),
			.side_o (side_c[g+1]),
			.lane_o (lane_c[g+1]),
			.p_o    (p_c[g+1])
		);
	end

	lstc_back u_back (
		.clk         (clk),
		.en          (free[PIPE_STAGES-1 -: BACK_STAGES]),
		.side_i      (side_c[CELLS]),
		.lane_i      (lane_c[CELLS]),
		.p_i         (p_c[CELLS]),
		.cfg         (cfg_q),
		.beam_number (beam_number),
		.laser_x     (laser_x),
		.laser_y     (laser_y),
		.map_x       (map_x),
		.map_y       (map_y),
		.map_valid   (map_valid),
		.end_of_scan (end_of_scan)
	);

endmodule

>>> src/lstc_checker.sv
// port level checks of the laser scan to cartesian core and their binding
module lstc_checker import lstc_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [BEAM_W-1:0]         beam_number,
	input logic signed [LASER_W-1:0] laser_x,
	input logic signed [LASER_W-1:0] laser_y,
	input logic signed [MAP_W-1:0]   map_x,
	input logic signed [MAP_W-1:0]   map_y,
	input logic                      map_valid
);

	// an empty output stage means the whole pipe can move
	a_ready_when_empty: assert property (@(posedge clk) !out_valid |-> !in_stall)
		else $error("input stalled with no output beat pending");

	// map coordinates are zero when not enabled
	a_map_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !map_valid |-> map_x == '0 && map_y == '0)
		else $error("map point nonzero without map_valid");

	// sensor frame magnitude never reaches 65536
	a_laser_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> laser_x != 17'h10000 && laser_y != 17'h10000)
		else $error("sensor frame point out of range");

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(laser_x) && $stable(beam_number))
		else $error("stalled output beat changed");

endmodule

bind laser_scan_to_cartesian_core lstc_checker u_lstc_checker (.*);
